// ===== rtl/core/hta_pkg.sv =====
// ----------------------------------------------------------------------------
// hta_pkg
// Shared types and constants of the HSL tone adjust pipeline.
// ----------------------------------------------------------------------------
package hta_pkg;

   localparam logic [16:0] UNIT_ONE  = 17'd65536;
   localparam logic [16:0] HALF_UNIT = 17'd32768;
   localparam logic [16:0] HUE_TURN  = 17'd23040;
   localparam logic [15:0] GAIN_ONE  = 16'd4096;

   // register indexes of the csr port
   localparam logic [2:0] CSR_HUE_OFFSET = 3'd0;
   localparam logic [2:0] CSR_SAT_GAIN   = 3'd1;
   localparam logic [2:0] CSR_LIGHT_GAIN = 3'd2;
   localparam logic [2:0] CSR_CONTRAST   = 3'd3;
   localparam logic [2:0] CSR_OPACITY    = 3'd4;

   // pipeline stage positions
   localparam int DIV_STEPS  = 17;
   localparam int STG_A      = 0;
   localparam int STG_B      = 1;
   localparam int DIV_FIRST  = 2;
   localparam int STG_C      = DIV_FIRST + DIV_STEPS;
   localparam int STG_D      = STG_C + 1;
   localparam int STG_E      = STG_C + 2;
   localparam int STG_F      = STG_C + 3;
   localparam int STG_G      = STG_C + 4;
   localparam int STG_H      = STG_C + 5;
   localparam int STG_K      = STG_C + 8;
   localparam int NUM_STAGES = STG_K + 1;

   typedef struct packed {
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
      logic [15:0] alpha_in;
      logic        is_background;
   } req_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
      logic [15:0] alpha_out;
   } rsp_type;

   // data that rides along untouched until the output stage
   typedef struct packed {
      logic        bypass;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
   } side_type;

   typedef enum logic [1:0] {
      HSEL_RED,
      HSEL_GREEN,
      HSEL_BLUE
   } hsel_type;

   typedef struct packed {
      logic [16:0] rem;
      logic [16:0] lo;
      logic [16:0] quo;
      logic [16:0] den;
   } div_lane_type;

   typedef struct packed {
      side_type     side;
      logic [16:0]  light;
      hsel_type     hsel;
      logic         hneg;
      logic         dpos;
      div_lane_type sat;
      div_lane_type hue;
   } div_type;

   typedef enum logic [1:0] {
      MODE_RISE,
      MODE_HIGH,
      MODE_FALL,
      MODE_LOW
   } chan_mode_type;

   typedef struct packed {
      logic [16:0]   span;
      logic [11:0]   arg;
      logic [16:0]   p;
      logic [16:0]   q;
      logic [16:0]   light;
      chan_mode_type mode;
      logic          grey;
   } chan_in_type;

endpackage

// ===== rtl/core/hta_div_step.sv =====
// ----------------------------------------------------------------------------
// hta_div_step
// One registered restoring-division step for the saturation and hue lanes.
// ----------------------------------------------------------------------------
module hta_div_step (
   input  logic             clock,
   input  logic             en,
   input  hta_pkg::div_type d_in,
   output hta_pkg::div_type d_out
);

   hta_pkg::div_type d_ff;
   hta_pkg::div_type d_in_next;

   function automatic hta_pkg::div_lane_type lane_step(input hta_pkg::div_lane_type a);
      logic [17:0]           trial;
      hta_pkg::div_lane_type b;
      b     = a;
      trial = {a.rem, a.lo[16]};
      b.lo  = {a.lo[15:0], 1'b0};
      if (trial >= {1'b0, a.den}) begin
         b.rem = 17'(trial - {1'b0, a.den});
         b.quo = {a.quo[15:0], 1'b1};
      end else begin
         b.rem = trial[16:0];
         b.quo = {a.quo[15:0], 1'b0};
      end
      return b;
   endfunction

   always_comb begin
      d_in_next     = d_in;
      d_in_next.sat = lane_step(d_in.sat);
      d_in_next.hue = lane_step(d_in.hue);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end

   assign d_out = d_ff;

endmodule

// ===== rtl/core/hta_chan.sv =====
// ----------------------------------------------------------------------------
// hta_chan
// Three-stage HSL-to-RGB channel: ramp product, divide by a sixth of a turn
// through a reciprocal, then select the channel level.
// ----------------------------------------------------------------------------
module hta_chan (
   input  logic                 clock,
   input  logic [2:0]           en,
   input  hta_pkg::chan_in_type c_in,
   output logic [16:0]          val
);

   logic [28:0]          x_ff;
   hta_pkg::chan_in_type h_ff;
   logic [19:0]          y_ff;
   logic [16:0]          qq_ff;
   hta_pkg::chan_in_type i_ff;
   logic [16:0]          val_ff;

   logic [29:0] x_rnd;
   logic [19:0] y_in;
   logic [35:0] z_mul;
   logic [16:0] qq_in;
   logic [20:0] rem;
   logic [16:0] ramp;
   logic [16:0] val_in;

   always_comb begin
      x_rnd = {1'b0, x_ff} + 30'd1920;
      y_in  = 20'(x_rnd >> 8);
      // y / 15 from below, fixed up in the next stage
      z_mul = {16'd0, y_in} * 36'd34952;
      qq_in = 17'(z_mul >> 19);
   end

   always_comb begin
      rem  = {1'b0, y_ff} - 21'({4'd0, qq_ff} * 21'd15);
      ramp = i_ff.p + qq_ff;
      if (rem >= 21'd30) begin
         ramp = 17'(ramp + 17'd2);
      end else if (rem >= 21'd15) begin
         ramp = 17'(ramp + 17'd1);
      end
      if (i_ff.grey) begin
         val_in = i_ff.light;
      end else begin
         case (i_ff.mode)
            hta_pkg::MODE_RISE: val_in = ramp;
            hta_pkg::MODE_FALL: val_in = ramp;
            hta_pkg::MODE_HIGH: val_in = i_ff.q;
            hta_pkg::MODE_LOW:  val_in = i_ff.p;
            default:            val_in = i_ff.p;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff <= 29'(c_in.span * c_in.arg);
         h_ff <= c_in;
      end
      if (en[1]) begin
         y_ff  <= y_in;
         qq_ff <= qq_in;
         i_ff  <= h_ff;
      end
      if (en[2]) begin
         val_ff <= val_in;
      end
   end

   assign val = val_ff;

endmodule

// ===== rtl/core/hsl_tone_adjust.sv =====
// ----------------------------------------------------------------------------
// hsl_tone_adjust
// RGBA tone adjust: RGB to HSL, hue shift, saturation/lightness/contrast
// gains, HSL back to RGB; background alpha scaled by opacity.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_ready with one RGBA color and a background
//   flag; responses leave on rsp_valid/rsp_ready, one per request, in order.
//   Gains and offsets are written through csr_write_en/csr_index/csr_wdata
//   while the pipeline is empty.
//   Throughput is one request per cycle unless a stalled response backs up the
//   pipeline. A request passes through two front stages, a 17-stage bit-serial
//   divider (one quotient bit per stage, saturation and hue side by side), then
//   nine stages of gain, contrast and HSL-to-RGB math.
//   Each stage has its own valid bit; a stage loads whenever it is empty or
//   the one after it moves, so a stalled response only holds the stages
//   behind it that are full and bubbles are squeezed out.
//   Synchronous reset empties the pipeline and loads neutral settings:
//   hue offset 0, all gains 1.0, opacity 1.0.
// ----------------------------------------------------------------------------
module hsl_tone_adjust (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hta_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hta_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [16:0]      csr_wdata
);

   typedef struct packed {
      hta_pkg::side_type side;
      logic [16:0]       r;
      logic [16:0]       g;
      logic [16:0]       b;
   } sa_type;

   typedef struct packed {
      hta_pkg::side_type  side;
      logic [16:0]        light;
      logic [32:0]        sprod;
      logic [32:0]        lprod;
      logic signed [17:0] h0;
   } sc_type;

   typedef struct packed {
      hta_pkg::side_type side;
      logic [16:0]       s;
      logic              dneg;
      logic [31:0]       cprod;
      logic [14:0]       h;
   } sd_type;

   typedef struct packed {
      hta_pkg::side_type         side;
      logic [16:0]               s;
      logic [16:0]               l2;
      hta_pkg::chan_mode_type [2:0] mode;
      logic [2:0][11:0]          arg;
   } se_type;

   typedef struct packed {
      hta_pkg::side_type         side;
      logic [16:0]               s;
      logic [16:0]               l2;
      logic                      lhalf;
      logic [32:0]               m;
      hta_pkg::chan_mode_type [2:0] mode;
      logic [2:0][11:0]          arg;
   } sf_type;

   logic signed [15:0] hue_offset_ff;
   logic [15:0]        sat_gain_ff;
   logic [15:0]        light_gain_ff;
   logic [15:0]        contrast_ff;
   logic [16:0]        opacity_ff;

   localparam int NUM_STAGES_L = hta_pkg::NUM_STAGES;
   logic [NUM_STAGES_L-1:0] v_ff;
   logic [NUM_STAGES_L:0]   en;

   sa_type            a_ff, a_in;
   hta_pkg::div_type  b_ff, b_in;
   hta_pkg::div_type  div_d [hta_pkg::DIV_STEPS+1];
   sc_type            c_ff, c_in;
   sd_type            d_ff, d_in;
   se_type            e_ff, e_in;
   sf_type            f_ff, f_in;
   hta_pkg::side_type g_side_ff, h_side_ff, i_side_ff, j_side_ff;
   hta_pkg::chan_in_type [2:0] g_ff, g_in;
   logic [2:0][16:0]  chan_val;
   hta_pkg::rsp_type  k_ff, k_in;

   // ---------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_offset_ff <= '0;
         sat_gain_ff   <= hta_pkg::GAIN_ONE;
         light_gain_ff <= hta_pkg::GAIN_ONE;
         contrast_ff   <= hta_pkg::GAIN_ONE;
         opacity_ff    <= hta_pkg::UNIT_ONE;
      end else if (csr_write_en) begin
         case (csr_index)
            hta_pkg::CSR_HUE_OFFSET: hue_offset_ff <= $signed(csr_wdata[15:0]);
            hta_pkg::CSR_SAT_GAIN:   sat_gain_ff   <= csr_wdata[15:0];
            hta_pkg::CSR_LIGHT_GAIN: light_gain_ff <= csr_wdata[15:0];
            hta_pkg::CSR_CONTRAST:   contrast_ff   <= csr_wdata[15:0];
            hta_pkg::CSR_OPACITY:    opacity_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage valids and enables
   assign en[NUM_STAGES_L] = rsp_ready;
   for (genvar gi = 0; gi < NUM_STAGES_L; gi++) begin : g_en
      assign en[gi] = ~v_ff[gi] | en[gi+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES_L; i++) begin
            if (en[i]) begin
               v_ff[i] <= (i == 0) ? req_valid : v_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NUM_STAGES_L-1];
   assign rsp_data  = k_ff;

   // ---------------- stage A: unit scaling, alpha
   logic [16:0] op_sat;
   logic [32:0] aprod;

   always_comb begin
      op_sat = (opacity_ff > hta_pkg::UNIT_ONE) ? hta_pkg::UNIT_ONE : opacity_ff;
      aprod  = {17'd0, req_data.alpha_in} * {16'd0, op_sat};
      a_in.side.bypass = (hue_offset_ff == 16'sd0) && (sat_gain_ff == hta_pkg::GAIN_ONE)
                      && (light_gain_ff == hta_pkg::GAIN_ONE)
                      && (contrast_ff == hta_pkg::GAIN_ONE);
      a_in.side.red   = req_data.red_in;
      a_in.side.green = req_data.green_in;
      a_in.side.blue  = req_data.blue_in;
      a_in.side.alpha = req_data.is_background ? aprod[31:16] : req_data.alpha_in;
      // x * 65536 / 65535 rounded is x plus one for the upper half
      a_in.r = {1'b0, req_data.red_in}   + {16'd0, req_data.red_in[15]};
      a_in.g = {1'b0, req_data.green_in} + {16'd0, req_data.green_in[15]};
      a_in.b = {1'b0, req_data.blue_in}  + {16'd0, req_data.blue_in[15]};
   end

   // ---------------- stage B: max/min, divider setup
   logic [16:0]        mx, mn, dd, den, mag;
   logic [17:0]        sum;
   logic signed [17:0] hnum;
   logic [33:0]        snum;
   logic [28:0]        hfull;

   always_comb begin
      b_in      = '0;
      b_in.side = a_ff.side;
      if (a_ff.r >= a_ff.g && a_ff.r >= a_ff.b) begin
         mx = a_ff.r;
         b_in.hsel = hta_pkg::HSEL_RED;
         hnum = $signed({1'b0, a_ff.g}) - $signed({1'b0, a_ff.b});
      end else if (a_ff.g >= a_ff.b) begin
         mx = a_ff.g;
         b_in.hsel = hta_pkg::HSEL_GREEN;
         hnum = $signed({1'b0, a_ff.b}) - $signed({1'b0, a_ff.r});
      end else begin
         mx = a_ff.b;
         b_in.hsel = hta_pkg::HSEL_BLUE;
         hnum = $signed({1'b0, a_ff.r}) - $signed({1'b0, a_ff.g});
      end
      mn = (a_ff.r <= a_ff.g) ? ((a_ff.r <= a_ff.b) ? a_ff.r : a_ff.b)
                              : ((a_ff.g <= a_ff.b) ? a_ff.g : a_ff.b);
      dd  = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      den = (sum > {1'b0, hta_pkg::UNIT_ONE}) ? 17'(18'd131072 - sum) : sum[16:0];
      mag = hnum[17] ? 17'(-hnum) : hnum[16:0];
      b_in.light = sum[17:1];
      b_in.hneg  = hnum[17];
      b_in.dpos  = (dd != 17'd0);
      snum  = {1'b0, dd, 16'd0} + {18'd0, den[16:1]};
      hfull = 29'({12'd0, mag} * 29'd3840) + {13'd0, dd[16:1]};
      b_in.sat.rem = 17'(snum >> 17);
      b_in.sat.lo  = snum[16:0];
      b_in.sat.den = den;
      b_in.hue.rem = 17'(hfull >> 17);
      b_in.hue.lo  = hfull[16:0];
      b_in.hue.den = dd;
   end

   // ---------------- divider steps
   assign div_d[0] = b_ff;
   for (genvar k = 0; k < hta_pkg::DIV_STEPS; k++) begin : g_div
      hta_div_step u_step (
         .clock (clock),
         .en    (en[hta_pkg::DIV_FIRST + k]),
         .d_in  (div_d[k]),
         .d_out (div_d[k+1])
      );
   end

   // ---------------- stage C: hue assembly, gain products
   hta_pkg::div_type   dq;
   logic [16:0]        s_raw;
   logic signed [17:0] hq_s, base;

   always_comb begin
      dq    = div_d[hta_pkg::DIV_STEPS];
      s_raw = dq.dpos ? dq.sat.quo : 17'd0;
      hq_s  = $signed({1'b0, dq.hue.quo});
      case (dq.hsel)
         hta_pkg::HSEL_RED:   base = dq.hneg ? 18'sd23040 : 18'sd0;
         hta_pkg::HSEL_GREEN: base = 18'sd7680;
         hta_pkg::HSEL_BLUE:  base = 18'sd15360;
         default:             base = 18'sd0;
      endcase
      c_in.side  = dq.side;
      c_in.light = dq.light;
      c_in.sprod = {16'd0, s_raw} * {17'd0, sat_gain_ff};
      c_in.lprod = {16'd0, dq.light} * {17'd0, light_gain_ff};
      c_in.h0    = dq.dpos ? (base + (dq.hneg ? -hq_s : hq_s)) : 18'sd0;
   end

   // ---------------- stage D: gain clamps, hue wrap, contrast product
   function automatic logic [16:0] gain_clamp(input logic [32:0] prod);
      logic [33:0] t;
      t = ({1'b0, prod} + 34'd2048) >> 12;
      return (t > 34'd65536) ? hta_pkg::UNIT_ONE : t[16:0];
   endfunction

   logic [16:0]        l1;
   logic [15:0]        cmag;
   logic signed [17:0] hx;
   logic [18:0]        hy19;
   logic [16:0]        hy;

   always_comb begin
      d_in.side = c_ff.side;
      d_in.s    = gain_clamp(c_ff.sprod);
      l1        = gain_clamp(c_ff.lprod);
      d_in.dneg = (l1 < hta_pkg::HALF_UNIT);
      cmag      = d_in.dneg ? 16'(hta_pkg::HALF_UNIT - l1) : 16'(l1 - hta_pkg::HALF_UNIT);
      d_in.cprod = {16'd0, cmag} * {16'd0, contrast_ff};
      hx   = c_ff.h0 + {{2{hue_offset_ff[15]}}, hue_offset_ff};
      hy19 = 19'({hx[17], hx} + 19'sd46080);
      hy   = hy19[16:0];
      if (hy >= 17'd69120) hy = hy - 17'd69120;
      if (hy >= 17'd46080) hy = hy - 17'd46080;
      if (hy >= hta_pkg::HUE_TURN) hy = hy - hta_pkg::HUE_TURN;
      d_in.h = hy[14:0];
   end

   // ---------------- stage E: contrast, channel hue segments
   logic [20:0]        csc;
   logic [21:0]        lup;
   logic signed [17:0] tch;

   always_comb begin
      e_in.side = d_ff.side;
      e_in.s    = d_ff.s;
      csc = 21'(({1'b0, d_ff.cprod} + 33'd2048) >> 12);
      lup = {5'd0, hta_pkg::HALF_UNIT} + {1'b0, csc};
      if (d_ff.dneg) begin
         e_in.l2 = (csc >= 21'd32768) ? 17'd0 : 17'(21'd32768 - csc);
      end else begin
         e_in.l2 = (lup > 22'd65536) ? hta_pkg::UNIT_ONE : lup[16:0];
      end
      for (int c = 0; c < 3; c++) begin
         tch = $signed({3'd0, d_ff.h});
         if (c == 0) tch = tch + 18'sd7680;
         if (c == 2) tch = tch - 18'sd7680;
         if (tch < 18'sd0) tch = tch + 18'sd23040;
         else if (tch > 18'sd23040) tch = tch - 18'sd23040;
         if (tch < 18'sd3840) begin
            e_in.mode[c] = hta_pkg::MODE_RISE;
            e_in.arg[c]  = tch[11:0];
         end else if (tch < 18'sd11520) begin
            e_in.mode[c] = hta_pkg::MODE_HIGH;
            e_in.arg[c]  = '0;
         end else if (tch < 18'sd15360) begin
            e_in.mode[c] = hta_pkg::MODE_FALL;
            e_in.arg[c]  = 12'(18'sd15360 - tch);
         end else begin
            e_in.mode[c] = hta_pkg::MODE_LOW;
            e_in.arg[c]  = '0;
         end
      end
   end

   // ---------------- stage F: q product
   logic [17:0] qmul;

   always_comb begin
      f_in.side  = e_ff.side;
      f_in.s     = e_ff.s;
      f_in.l2    = e_ff.l2;
      f_in.mode  = e_ff.mode;
      f_in.arg   = e_ff.arg;
      f_in.lhalf = (e_ff.l2 < hta_pkg::HALF_UNIT);
      qmul = f_in.lhalf ? (18'd65536 + {1'b0, e_ff.s}) : {1'b0, e_ff.s};
      f_in.m = 33'({18'd0, e_ff.l2} * {17'd0, qmul});
   end

   // ---------------- stage G: p and q
   logic [16:0] mr, qv, pv;

   always_comb begin
      mr = 17'(({1'b0, f_ff.m} + 34'd32768) >> 16);
      qv = f_ff.lhalf ? mr : 17'({1'b0, f_ff.l2} + {1'b0, f_ff.s} - {1'b0, mr});
      pv = 17'({f_ff.l2, 1'b0} - {1'b0, qv});
      for (int c = 0; c < 3; c++) begin
         g_in[c].span  = qv - pv;
         g_in[c].arg   = f_ff.arg[c];
         g_in[c].p     = pv;
         g_in[c].q     = qv;
         g_in[c].light = f_ff.l2;
         g_in[c].mode  = f_ff.mode[c];
         g_in[c].grey  = (f_ff.s == 17'd0);
      end
   end

   // ---------------- stages H..J: channel units
   for (genvar c = 0; c < 3; c++) begin : g_chan
      hta_chan u_chan (
         .clock (clock),
         .en    (en[hta_pkg::STG_H +: 3]),
         .c_in  (g_ff[c]),
         .val   (chan_val[c])
      );
   end

   // ---------------- stage K: channel codes, output register
   function automatic logic [15:0] to_code(input logic [16:0] v);
      return 16'(v - {16'd0, (v > hta_pkg::HALF_UNIT)});
   endfunction

   always_comb begin
      k_in.alpha_out = j_side_ff.alpha;
      if (j_side_ff.bypass) begin
         k_in.red_out   = j_side_ff.red;
         k_in.green_out = j_side_ff.green;
         k_in.blue_out  = j_side_ff.blue;
      end else begin
         k_in.red_out   = to_code(chan_val[0]);
         k_in.green_out = to_code(chan_val[1]);
         k_in.blue_out  = to_code(chan_val[2]);
      end
   end

   // ---------------- data registers
   always_ff @(posedge clock) begin
      if (en[hta_pkg::STG_A]) a_ff <= a_in;
      if (en[hta_pkg::STG_B]) b_ff <= b_in;
      if (en[hta_pkg::STG_C]) c_ff <= c_in;
      if (en[hta_pkg::STG_D]) d_ff <= d_in;
      if (en[hta_pkg::STG_E]) e_ff <= e_in;
      if (en[hta_pkg::STG_F]) f_ff <= f_in;
      if (en[hta_pkg::STG_G]) begin
         g_ff      <= g_in;
         g_side_ff <= f_ff.side;
      end
      if (en[hta_pkg::STG_H])     h_side_ff <= g_side_ff;
      if (en[hta_pkg::STG_H + 1]) i_side_ff <= h_side_ff;
      if (en[hta_pkg::STG_H + 2]) j_side_ff <= i_side_ff;
      if (en[hta_pkg::STG_K])     k_ff      <= k_in;
   end

endmodule

// ===== tb/sv/hsl_tone_adjust_tb.sv =====
// ----------------------------------------------------------------------------
// hsl_tone_adjust_tb
// Self-checking bench for the HSL tone adjust pipeline. Drives RGBA requests
// under several register settings with random idling on both sides, predicts
// every response in fixed point and checks responses in order.
// ----------------------------------------------------------------------------
module hsl_tone_adjust_tb;

   localparam int SIXTH    = 3840;
   localparam int TURN     = 23040;
   localparam int ONE      = 65536;
   localparam int HALF     = 32768;
   localparam int WD_LIMIT = 2000;
   localparam int LATENCY  = 28;

   // predictor settings
   class tone_settings;
      logic [15:0] hue_off;
      logic [15:0] sat_gain;
      logic [15:0] light_gain;
      logic [15:0] con_gain;
      logic [16:0] opacity;
   endclass

   function automatic longint clamp1(longint v);
      if (v < 0) return 0;
      if (v > ONE) return ONE;
      return v;
   endfunction

   function automatic longint div_round(longint num, longint den);
      longint mag;
      longint q;
      mag = num < 0 ? -num : num;
      q = (mag * SIXTH + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic longint scale_gain(longint v, longint g);
      longint prod;
      prod = (v * g + 2048) >>> 12;
      return prod > ONE ? ONE : prod;
   endfunction

   function automatic longint chan_of(longint p, longint q, longint t);
      longint span;
      span = q - p;
      if (t < 0) t += TURN;
      if (t > TURN) t -= TURN;
      if (t < SIXTH) return p + (span * t + SIXTH / 2) / SIXTH;
      if (t < 3 * SIXTH) return q;
      if (t < 4 * SIXTH) return p + (span * (4 * SIXTH - t) + SIXTH / 2) / SIXTH;
      return p;
   endfunction

   function automatic logic [15:0] unit_to_code(longint v);
      longint c;
      c = clamp1(v);
      return 16'((c * 65535 + 32768) >>> 16);
   endfunction

   function automatic hta_pkg::rsp_type predict_tone(tone_settings cs, hta_pkg::req_type rq);
      hta_pkg::rsp_type o;
      longint op, r, g, b, mx, mn, d, sum, h, s, l, den, off, diff, mag, sc, p, q;
      op = cs.opacity > ONE ? ONE : cs.opacity;
      o.alpha_out = rq.is_background ? 16'((longint'(rq.alpha_in) * op) >>> 16)
                                     : rq.alpha_in;
      if (cs.hue_off == 0 && cs.sat_gain == hta_pkg::GAIN_ONE &&
          cs.light_gain == hta_pkg::GAIN_ONE && cs.con_gain == hta_pkg::GAIN_ONE) begin
         o.red_out = rq.red_in;
         o.green_out = rq.green_in;
         o.blue_out = rq.blue_in;
         return o;
      end
      r = (longint'(rq.red_in) * 65536 + 32767) / 65535;
      g = (longint'(rq.green_in) * 65536 + 32767) / 65535;
      b = (longint'(rq.blue_in) * 65536 + 32767) / 65535;
      mx = r > g ? (r > b ? r : b) : (g > b ? g : b);
      mn = r < g ? (r < b ? r : b) : (g < b ? g : b);
      d = mx - mn;
      sum = mx + mn;
      h = 0;
      s = 0;
      l = sum >>> 1;
      if (d > 0) begin
         den = sum > ONE ? 2 * ONE - sum : sum;
         s = clamp1((d * ONE + den / 2) / den);
         if (mx == r) h = div_round(g - b, d) + (g < b ? TURN : 0);
         else if (mx == g) h = div_round(b - r, d) + 2 * SIXTH;
         else h = div_round(r - g, d) + 4 * SIXTH;
      end
      off = longint'($signed(cs.hue_off));
      h = ((h + off) % TURN + TURN) % TURN;
      s = scale_gain(s, cs.sat_gain);
      l = scale_gain(l, cs.light_gain);
      diff = l - HALF;
      mag = diff < 0 ? -diff : diff;
      sc = (mag * cs.con_gain + 2048) / 4096;
      l = clamp1(HALF + (diff < 0 ? -sc : sc));
      if (s == 0) begin
         r = l; g = l; b = l;
      end else begin
         if (l < HALF) q = (l * (ONE + s) + HALF) >>> 16;
         else q = l + s - ((l * s + HALF) >>> 16);
         p = 2 * l - q;
         r = chan_of(p, q, h + 2 * SIXTH);
         g = chan_of(p, q, h);
         b = chan_of(p, q, h - 2 * SIXTH);
      end
      o.red_out = unit_to_code(r);
      o.green_out = unit_to_code(g);
      o.blue_out = unit_to_code(b);
      return o;
   endfunction

   int errors = 0;

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   class tone_board;
      tone_settings cs;
      hta_pkg::rsp_type pending[$];
      function new();
         cs = new();
      endfunction
      function void note_request(hta_pkg::req_type rq);
         pending.push_back(predict_tone(cs, rq));
      endfunction
      task check_response(hta_pkg::rsp_type got);
         hta_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
            return;
         end
         want = pending.pop_front();
         if (got.red_out !== want.red_out)
            report_mismatch("red", int'(got.red_out), int'(want.red_out));
         if (got.green_out !== want.green_out)
            report_mismatch("green", int'(got.green_out), int'(want.green_out));
         if (got.blue_out !== want.blue_out)
            report_mismatch("blue", int'(got.blue_out), int'(want.blue_out));
         if (got.alpha_out !== want.alpha_out)
            report_mismatch("alpha", int'(got.alpha_out), int'(want.alpha_out));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   hta_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   hta_pkg::rsp_type rsp_data;
   logic csr_write_en = 0;
   logic [2:0] csr_index = '0;
   logic [16:0] csr_wdata = '0;

   bit quiet = 0;
   int stall_left = 0;
   int watchdog = 0;
   tone_board board = new();

   hsl_tone_adjust dut (.*);

   always #10 clock = ~clock;

   // sampling and checking at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) watchdog = 0;
         else watchdog++;
         if (watchdog >= WD_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (quiet) rsp_ready <= 1;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 0;
      end else rsp_ready <= 1;
   end

   task automatic write_reg(logic [2:0] idx, logic [16:0] val);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 0;
      case (idx)
         hta_pkg::CSR_HUE_OFFSET: board.cs.hue_off = val[15:0];
         hta_pkg::CSR_SAT_GAIN:   board.cs.sat_gain = val[15:0];
         hta_pkg::CSR_LIGHT_GAIN: board.cs.light_gain = val[15:0];
         hta_pkg::CSR_CONTRAST:   board.cs.con_gain = val[15:0];
         default:                 board.cs.opacity = val;
      endcase
   endtask

   task automatic set_all(logic [15:0] hoff, logic [15:0] sg, logic [15:0] lg,
                          logic [15:0] cg, logic [16:0] op);
      write_reg(hta_pkg::CSR_HUE_OFFSET, {1'b0, hoff});
      write_reg(hta_pkg::CSR_SAT_GAIN, {1'b0, sg});
      write_reg(hta_pkg::CSR_LIGHT_GAIN, {1'b0, lg});
      write_reg(hta_pkg::CSR_CONTRAST, {1'b0, cg});
      write_reg(hta_pkg::CSR_OPACITY, op);
   endtask

   // sits at a falling edge; holds valid across back-to-back requests
   task automatic send_request(hta_pkg::req_type rq);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic hta_pkg::req_type random_request();
      hta_pkg::req_type rq;
      int k;
      k = $urandom_range(0, 9);
      rq.red_in = 16'($urandom);
      rq.green_in = 16'($urandom);
      rq.blue_in = 16'($urandom);
      rq.alpha_in = 16'($urandom);
      rq.is_background = 1'($urandom);
      if (k == 0) begin
         rq.green_in = rq.red_in;
         rq.blue_in = rq.red_in;
      end else if (k == 1) rq.green_in = rq.red_in;
      else if (k == 2) begin
         rq.red_in = 16'hFFFF;
         rq.blue_in = 0;
      end
      return rq;
   endfunction

   function automatic hta_pkg::req_type mk(int r, int g, int b, int a, bit bg);
      hta_pkg::req_type rq;
      rq.red_in = 16'(r);
      rq.green_in = 16'(g);
      rq.blue_in = 16'(b);
      rq.alpha_in = 16'(a);
      rq.is_background = bg;
      return rq;
   endfunction

   logic [15:0] hue_pick[6] = '{16'd0, 16'd23040, -16'sd23040, 16'd11520, 16'hFFFF, 16'd64};
   logic [15:0] gain_pick[6] = '{16'd0, 16'd4096, 16'd65535, 16'd2048, 16'd6144, 16'd8192};
   logic [16:0] op_pick[5] = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd65535};

   initial begin
      hta_pkg::req_type rq;
      board.cs.hue_off = 0;
      board.cs.sat_gain = hta_pkg::GAIN_ONE;
      board.cs.light_gain = hta_pkg::GAIN_ONE;
      board.cs.con_gain = hta_pkg::GAIN_ONE;
      board.cs.opacity = hta_pkg::UNIT_ONE;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: neutral pass-through, then a shifted setting
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) set_all(16'd7680, 16'd6144, 16'd3000, 16'd8192, 17'd40000);
         send_request(mk(0, 0, 0, 0, 0));
         send_request(mk(65535, 65535, 65535, 65535, 1));
         send_request(mk(65535, 0, 0, 65535, 1));
         send_request(mk(0, 65535, 0, 1, 0));
         send_request(mk(0, 0, 65535, 32768, 1));
         send_request(mk(30000, 30000, 30000, 100, 1));
         send_request(mk(65535, 0, 65535, 65535, 0));
         send_request(mk(1000, 2000, 60000, 65535, 1));
         send_request(mk(40000, 50000, 10000, 12345, 1));
         send_request(mk(12, 65000, 65000, 500, 0));
         send_request(mk(1, 0, 0, 7, 1));
         drain();
      end

      // random phases over extreme and mixed settings
      for (int ph = 0; ph < 17; ph++) begin
         if (ph == 16) quiet = 1;
         if (ph == 0)
            set_all(16'd0, hta_pkg::GAIN_ONE, hta_pkg::GAIN_ONE, hta_pkg::GAIN_ONE,
                    17'd131071);
         else if (ph == 1) set_all(16'hFFFF, 16'd65535, 16'd65535, 16'd65535, 17'd0);
         else if (ph == 2) set_all(16'd23040, 16'd0, 16'd0, 16'd0, 17'd65536);
         else if (ph % 2 == 1)
            set_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 12000)),
                    16'($urandom_range(0, 12000)), 17'($urandom));
         else
            set_all(hue_pick[$urandom_range(0, 5)], gain_pick[$urandom_range(0, 5)],
                    gain_pick[$urandom_range(0, 5)], gain_pick[$urandom_range(0, 5)],
                    op_pick[$urandom_range(0, 4)]);
         for (int i = 0; i < 100; i++) begin
            rq = random_request();
            send_request(rq);
         end
         drain();
      end

      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/hta_pkg.sv
rtl/core/hta_div_step.sv
rtl/core/hta_chan.sv
rtl/core/hsl_tone_adjust.sv
tb/sv/hsl_tone_adjust_tb.sv
